FILE: hdl/jacobi_linear_solver_unit_defines.svh
// assertion macros of the jacobi solver rtl
// no dependencies; taken in by `include where assertions are written
`ifndef JACOBI_LINEAR_SOLVER_UNIT_DEFINES_SVH
`define JACOBI_LINEAR_SOLVER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define JLS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is held
`define JLS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/jls_pkg.sv
// shared types, constants and codes of the jacobi solver
// no dependencies; used by every module of the block
package jls_pkg;

    localparam int MAX_SIZE_DEF  = 16;
    localparam int FRAC_BITS_DEF = 16;

    localparam int DATA_W    = 32;
    localparam int WIDE_W    = 64;
    localparam int SWEEP_W   = 16;
    localparam int SIZE_W    = 5;
    localparam int ROW_W     = 4;
    localparam int OP_W      = 2;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 56;

    localparam logic [SIZE_W-1:0]  SIZE_RST   = SIZE_W'(16);
    localparam logic [SWEEP_W-1:0] LIMIT_RST  = SWEEP_W'(1000);
    localparam logic [DATA_W-1:0]  THRESH_RST = DATA_W'(66);

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_A = 2'd0,
        OP_LOAD_B = 2'd1,
        OP_START  = 2'd2
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        RES_CONVERGED = 2'd0,
        RES_LIMIT     = 2'd1,
        RES_ZERO_DIAG = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SIZE   = 2'd0,
        CFG_LIMIT  = 2'd1,
        CFG_THRESH = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_INIT_CHK,
        S_ROW_START,
        S_MAC_RD,
        S_MAC_MUL,
        S_MAC_ACC,
        S_DIAG_RD,
        S_NUM,
        S_DIV,
        S_QUO,
        S_SQ,
        S_SUM,
        S_SWEEP_END,
        S_EMIT_RD,
        S_EMIT_OUT
    } state_t;

    typedef struct packed {
        logic clear_run;
        logic init_wr;
        logic acc_clr;
        logic mac_mul;
        logic mac_acc;
        logic div_start;
        logic quo_wr;
        logic sq;
        logic sum_clr;
        logic sum_add;
        logic swap;
        logic emit_load;
    } cmd_t;

    typedef struct packed {
        logic zero_diag;
        logic converged;
        logic div_done;
    } dp_stat_t;

endpackage

FILE: hdl/jls_div.sv
// signed 64 by 32 bit divider, one quotient bit per cycle, truncating, saturated to 32 bits
// depends on jls_pkg
module jls_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start_i,
    input  logic signed [jls_pkg::WIDE_W-1:0] num_i,
    input  logic signed [jls_pkg::DATA_W-1:0] den_i,
    output logic                             done_o,
    output logic        [jls_pkg::DATA_W-1:0] quot_o
);

    localparam int CNT_W = $clog2(jls_pkg::WIDE_W);
    localparam logic [jls_pkg::WIDE_W-1:0] POS_MAX = jls_pkg::WIDE_W'(32'h7fff_ffff);
    localparam logic [jls_pkg::WIDE_W-1:0] NEG_MAX = jls_pkg::WIDE_W'(32'h8000_0000);

    logic                        busy_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [jls_pkg::DATA_W-1:0]  rem_reg;
    logic [jls_pkg::WIDE_W-1:0]  quo_reg;
    logic [jls_pkg::DATA_W-1:0]  den_reg;
    logic                        neg_reg;
    logic                        done_reg;
    logic [jls_pkg::DATA_W-1:0]  q_reg;

    logic [jls_pkg::DATA_W:0]    rem_sh;
    logic [jls_pkg::DATA_W+1:0]  trial;
    logic                        fits;
    logic [jls_pkg::WIDE_W-1:0]  quo_next;
    logic [jls_pkg::WIDE_W-1:0]  quo_neg;
    logic [jls_pkg::DATA_W-1:0]  q_sat;

    // one restoring step
    always_comb begin
        rem_sh   = {rem_reg, quo_reg[jls_pkg::WIDE_W-1]};
        trial    = {1'b0, rem_sh} - {2'b00, den_reg};
        fits     = !trial[jls_pkg::DATA_W+1];
        quo_next = {quo_reg[jls_pkg::WIDE_W-2:0], fits};
        quo_neg  = ~quo_next + jls_pkg::WIDE_W'(1);
        if (!neg_reg) begin
            q_sat = (quo_next > POS_MAX) ? POS_MAX[jls_pkg::DATA_W-1:0]
                                         : quo_next[jls_pkg::DATA_W-1:0];
        end else begin
            q_sat = (quo_next > NEG_MAX) ? NEG_MAX[jls_pkg::DATA_W-1:0]
                                         : quo_neg[jls_pkg::DATA_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start_i) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(jls_pkg::WIDE_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (start_i) begin
            rem_reg <= '0;
            quo_reg <= num_i[jls_pkg::WIDE_W-1] ? (~num_i + jls_pkg::WIDE_W'(1)) : num_i;
            den_reg <= den_i[jls_pkg::DATA_W-1] ? (~den_i + jls_pkg::DATA_W'(1)) : den_i;
            neg_reg <= num_i[jls_pkg::WIDE_W-1] ^ den_i[jls_pkg::DATA_W-1];
        end else if (busy_reg) begin
            rem_reg <= fits ? trial[jls_pkg::DATA_W-1:0] : rem_sh[jls_pkg::DATA_W-1:0];
            quo_reg <= quo_next;
            if (cnt_reg == CNT_W'(jls_pkg::WIDE_W - 1)) begin
                q_reg <= q_sat;
            end
        end
    end

    assign done_o = done_reg;
    assign quot_o = q_reg;

endmodule

FILE: hdl/jls_dp.sv
// datapath of the jacobi solver: stores, multiply-accumulate, change sum, divider
// depends on jls_pkg and jls_div
module jls_dp #(
    parameter int MAX_SIZE  = jls_pkg::MAX_SIZE_DEF,
    parameter int FRAC_BITS = jls_pkg::FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                ld_a_i,
    input  logic                                ld_b_i,
    input  logic [$clog2(MAX_SIZE)-1:0]         ld_row_i,
    input  logic [$clog2(MAX_SIZE)-1:0]         ld_col_i,
    input  logic [jls_pkg::DATA_W-1:0]          ld_value_i,
    input  jls_pkg::cmd_t                       cmd_i,
    input  logic [$clog2(MAX_SIZE)-1:0]         mat_row_i,
    input  logic [$clog2(MAX_SIZE)-1:0]         mat_col_i,
    input  logic [$clog2(MAX_SIZE)-1:0]         x_idx_i,
    input  logic [jls_pkg::DATA_W-1:0]          thresh_i,
    output jls_pkg::dp_stat_t                   stat_o,
    output logic [jls_pkg::DATA_W-1:0]          x_rd_o
);

    localparam int IW    = $clog2(MAX_SIZE);
    // row and column are concatenated into the address, so the store spans whole index ranges
    localparam int DEPTH = 1 << (2 * IW);
    localparam int DW    = jls_pkg::DATA_W;
    localparam int WW    = jls_pkg::WIDE_W;
    localparam logic signed [WW-1:0] SAT_POS = {1'b0, {(WW-1){1'b1}}};
    localparam logic signed [WW-1:0] SAT_NEG = {1'b1, {(WW-2){1'b0}}, 1'b1};

    function automatic logic signed [WW-1:0] sat_add(input logic signed [WW-1:0] a,
                                                     input logic signed [WW-1:0] b);
        logic signed [WW:0] s;
        logic signed [WW-1:0] r;
        s = {a[WW-1], a} + {b[WW-1], b};
        if (!s[WW] && s[WW-1]) begin
            r = SAT_POS;
        end else if (s[WW] && (!s[WW-1] || s[WW-2:0] == '0)) begin
            r = SAT_NEG;
        end else begin
            r = s[WW-1:0];
        end
        return r;
    endfunction

    logic [DW-1:0] mat_mem [DEPTH];
    logic [DW-1:0] rhs_mem [MAX_SIZE];
    logic [DW-1:0] x_mem   [2 << IW];

    logic [DW-1:0]          mat_rdata_reg;
    logic [DW-1:0]          rhs_rdata_reg;
    logic [DW-1:0]          x_rd_reg;
    logic                   sel_reg;
    logic                   chk_reg;
    logic [IW-1:0]          init_idx_reg;
    logic                   zero_reg;
    logic signed [WW-1:0]   prod_reg;
    logic signed [WW-1:0]   acc_reg;
    logic [DW-1:0]          ad_reg;
    logic [WW-1:0]          sq_reg;
    logic [WW-1:0]          sum_reg;

    logic signed [DW-1:0]   a_s;
    logic signed [DW-1:0]   x_s;
    logic signed [WW-1:0]   b_ext;
    logic signed [WW-1:0]   num;
    logic [DW-1:0]          quot;
    logic                   div_done;
    logic signed [DW:0]     diff;
    logic [WW-1:0]          term;
    logic [WW:0]            sum_wide;

    // matrix and rhs stores, registered reads
    always_ff @(posedge aclk) begin
        if (ld_a_i) begin
            mat_mem[{ld_row_i, ld_col_i}] <= ld_value_i;
        end
        mat_rdata_reg <= mat_mem[{mat_row_i, mat_col_i}];
    end

    always_ff @(posedge aclk) begin
        if (ld_b_i) begin
            rhs_mem[ld_row_i] <= ld_value_i;
        end
        rhs_rdata_reg <= rhs_mem[mat_row_i];
    end

    // solution double buffer: bank sel_reg holds the old vector
    always_ff @(posedge aclk) begin
        if (chk_reg) begin
            x_mem[{sel_reg, init_idx_reg}] <= rhs_rdata_reg;
        end else if (cmd_i.quo_wr) begin
            x_mem[{~sel_reg, x_idx_i}] <= quot;
        end
        x_rd_reg <= x_mem[{sel_reg, x_idx_i}];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg  <= 1'b0;
            chk_reg  <= 1'b0;
            zero_reg <= 1'b0;
        end else begin
            chk_reg <= cmd_i.init_wr;
            if (cmd_i.clear_run) begin
                sel_reg  <= 1'b0;
                zero_reg <= 1'b0;
            end else begin
                if (cmd_i.swap) begin
                    sel_reg <= ~sel_reg;
                end
                if (chk_reg && mat_rdata_reg == '0) begin
                    zero_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        init_idx_reg <= mat_row_i;
    end

    always_comb begin
        a_s      = mat_rdata_reg;
        x_s      = x_rd_reg;
        b_ext    = {{(WW-DW){rhs_rdata_reg[DW-1]}}, rhs_rdata_reg} <<< FRAC_BITS;
        num      = sat_add(b_ext, -acc_reg);
        diff     = {quot[DW-1], quot} - {x_rd_reg[DW-1], x_rd_reg};
        term     = sq_reg >> FRAC_BITS;
        sum_wide = {1'b0, sum_reg} + {1'b0, term};
    end

    // arithmetic pipeline, one step per command
    always_ff @(posedge aclk) begin
        if (cmd_i.mac_mul) begin
            prod_reg <= a_s * x_s;
        end
        if (cmd_i.acc_clr) begin
            acc_reg <= '0;
        end else if (cmd_i.mac_acc) begin
            acc_reg <= sat_add(acc_reg, prod_reg);
        end
        if (cmd_i.quo_wr) begin
            ad_reg <= diff[DW] ? DW'(-diff) : diff[DW-1:0];
        end
        if (cmd_i.sq) begin
            sq_reg <= ad_reg * ad_reg;
        end
        if (cmd_i.sum_clr) begin
            sum_reg <= '0;
        end else if (cmd_i.sum_add) begin
            sum_reg <= sum_wide[WW] ? {WW{1'b1}} : sum_wide[WW-1:0];
        end
    end

    jls_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (cmd_i.div_start),
        .num_i   (num),
        .den_i   (mat_rdata_reg),
        .done_o  (div_done),
        .quot_o  (quot)
    );

    assign stat_o.zero_diag = zero_reg | (chk_reg & (mat_rdata_reg == '0));
    assign stat_o.converged = (sum_reg <= {{(WW-DW){1'b0}}, thresh_i});
    assign stat_o.div_done  = div_done;
    assign x_rd_o           = x_rd_reg;

endmodule

FILE: hdl/jls_ctrl.sv
// sequencing state machine of the jacobi solver
// depends on jls_pkg and jacobi_linear_solver_unit_defines.svh
`include "jacobi_linear_solver_unit_defines.svh"

module jls_ctrl #(
    parameter int MAX_SIZE = jls_pkg::MAX_SIZE_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start_i,
    input  logic [jls_pkg::SIZE_W-1:0]         size_i,
    input  logic [jls_pkg::SWEEP_W-1:0]        limit_i,
    input  logic                               out_free_i,
    input  jls_pkg::dp_stat_t                  stat_i,
    output jls_pkg::cmd_t                      cmd_o,
    output logic [$clog2(MAX_SIZE)-1:0]        mat_row_o,
    output logic [$clog2(MAX_SIZE)-1:0]        mat_col_o,
    output logic [$clog2(MAX_SIZE)-1:0]        x_idx_o,
    output logic                               idle_o,
    output logic [jls_pkg::SWEEP_W-1:0]        sweeps_o,
    output jls_pkg::status_t                   status_o,
    output logic                               last_o
);

    localparam int IW = $clog2(MAX_SIZE);
    localparam int CW = $clog2(MAX_SIZE + 1);
    localparam int SW = jls_pkg::SWEEP_W;

    jls_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]    n_reg, n_next;
    logic [IW-1:0]    i_reg, i_next;
    logic [IW-1:0]    j_reg, j_next;
    logic [SW-1:0]    limit_reg, limit_next;
    logic [SW-1:0]    count_reg, count_next;
    jls_pkg::status_t status_reg, status_next;

    logic [IW-1:0]    last_idx;
    logic [SW:0]      count_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= jls_pkg::S_IDLE;
            n_reg      <= CW'(1);
            i_reg      <= '0;
            j_reg      <= '0;
            limit_reg  <= SW'(1);
            count_reg  <= '0;
            status_reg <= jls_pkg::RES_CONVERGED;
        end else begin
            state_reg  <= state_next;
            n_reg      <= n_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            limit_reg  <= limit_next;
            count_reg  <= count_next;
            status_reg <= status_next;
        end
    end

    always_comb begin
        last_idx    = IW'(n_reg - CW'(1));
        count_inc   = {1'b0, count_reg} + (SW+1)'(1);
        state_next  = state_reg;
        n_next      = n_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        limit_next  = limit_reg;
        count_next  = count_reg;
        status_next = status_reg;
        cmd_o       = '0;
        mat_row_o   = i_reg;
        mat_col_o   = i_reg;
        x_idx_o     = i_reg;

        unique case (state_reg)
            jls_pkg::S_IDLE: begin
                if (start_i) begin
                    if (size_i == '0) begin
                        n_next = CW'(1);
                    end else if (int'(size_i) > MAX_SIZE) begin
                        n_next = CW'(MAX_SIZE);
                    end else begin
                        n_next = CW'(size_i);
                    end
                    limit_next      = (limit_i == '0) ? SW'(1) : limit_i;
                    count_next      = '0;
                    status_next     = jls_pkg::RES_CONVERGED;
                    i_next          = '0;
                    j_next          = '0;
                    cmd_o.clear_run = 1'b1;
                    state_next      = jls_pkg::S_INIT;
                end
            end
            jls_pkg::S_INIT: begin
                cmd_o.init_wr = 1'b1;
                if (i_reg == last_idx) begin
                    state_next = jls_pkg::S_INIT_CHK;
                end else begin
                    i_next = i_reg + IW'(1);
                end
            end
            jls_pkg::S_INIT_CHK: begin
                i_next = '0;
                if (stat_i.zero_diag) begin
                    status_next = jls_pkg::RES_ZERO_DIAG;
                    state_next  = jls_pkg::S_EMIT_RD;
                end else begin
                    cmd_o.sum_clr = 1'b1;
                    state_next    = jls_pkg::S_ROW_START;
                end
            end
            jls_pkg::S_ROW_START: begin
                cmd_o.acc_clr = 1'b1;
                j_next        = '0;
                state_next    = jls_pkg::S_MAC_RD;
            end
            jls_pkg::S_MAC_RD: begin
                mat_col_o = j_reg;
                x_idx_o   = j_reg;
                if (j_reg == i_reg) begin
                    // diagonal term stays out of the sum
                    if (j_reg == last_idx) begin
                        state_next = jls_pkg::S_DIAG_RD;
                    end else begin
                        j_next = j_reg + IW'(1);
                    end
                end else begin
                    state_next = jls_pkg::S_MAC_MUL;
                end
            end
            jls_pkg::S_MAC_MUL: begin
                cmd_o.mac_mul = 1'b1;
                state_next    = jls_pkg::S_MAC_ACC;
            end
            jls_pkg::S_MAC_ACC: begin
                cmd_o.mac_acc = 1'b1;
                if (j_reg == last_idx) begin
                    state_next = jls_pkg::S_DIAG_RD;
                end else begin
                    j_next     = j_reg + IW'(1);
                    state_next = jls_pkg::S_MAC_RD;
                end
            end
            jls_pkg::S_DIAG_RD: begin
                state_next = jls_pkg::S_NUM;
            end
            jls_pkg::S_NUM: begin
                cmd_o.div_start = 1'b1;
                state_next      = jls_pkg::S_DIV;
            end
            jls_pkg::S_DIV: begin
                if (stat_i.div_done) begin
                    state_next = jls_pkg::S_QUO;
                end
            end
            jls_pkg::S_QUO: begin
                cmd_o.quo_wr = 1'b1;
                state_next   = jls_pkg::S_SQ;
            end
            jls_pkg::S_SQ: begin
                cmd_o.sq   = 1'b1;
                state_next = jls_pkg::S_SUM;
            end
            jls_pkg::S_SUM: begin
                cmd_o.sum_add = 1'b1;
                if (i_reg == last_idx) begin
                    state_next = jls_pkg::S_SWEEP_END;
                end else begin
                    i_next     = i_reg + IW'(1);
                    state_next = jls_pkg::S_ROW_START;
                end
            end
            jls_pkg::S_SWEEP_END: begin
                cmd_o.swap = 1'b1;
                count_next = count_inc[SW-1:0];
                i_next     = '0;
                if (stat_i.converged) begin
                    status_next = jls_pkg::RES_CONVERGED;
                    state_next  = jls_pkg::S_EMIT_RD;
                end else if (count_inc >= {1'b0, limit_reg}) begin
                    status_next = jls_pkg::RES_LIMIT;
                    state_next  = jls_pkg::S_EMIT_RD;
                end else begin
                    cmd_o.sum_clr = 1'b1;
                    state_next    = jls_pkg::S_ROW_START;
                end
            end
            jls_pkg::S_EMIT_RD: begin
                state_next = jls_pkg::S_EMIT_OUT;
            end
            jls_pkg::S_EMIT_OUT: begin
                if (out_free_i) begin
                    cmd_o.emit_load = 1'b1;
                    if (i_reg == last_idx) begin
                        state_next = jls_pkg::S_IDLE;
                    end else begin
                        i_next     = i_reg + IW'(1);
                        state_next = jls_pkg::S_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = jls_pkg::S_IDLE;
            end
        endcase
    end

    assign idle_o   = (state_reg == jls_pkg::S_IDLE);
    assign sweeps_o = count_reg;
    assign status_o = status_reg;
    assign last_o   = (i_reg == last_idx);

    `JLS_ASSERT_NOW(a_done_in_div, aclk, aresetn, stat_i.div_done, state_reg == jls_pkg::S_DIV, "divider finished outside its wait state")
    `JLS_ASSERT_NOW(a_emit_free, aclk, aresetn, cmd_o.emit_load, out_free_i, "result loaded into an occupied output register")
    `JLS_ASSERT_NEXT(a_start_init, aclk, aresetn, idle_o && start_i, state_reg == jls_pkg::S_INIT && i_reg == '0, "start did not begin the copy pass")
    `JLS_ASSERT_NOW(a_index_range, aclk, aresetn, !idle_o, i_reg <= last_idx && j_reg <= last_idx, "row or column counter beyond the system size")

endmodule

FILE: hdl/jacobi_linear_solver_unit.sv
// jacobi solver: a load completes in its transfer; a start runs a copy and zero-diagonal
// check pass, then sweeps over the rows (serial divider per row), then emits one element
// per row; one solve at a time, loads wait while it runs
// aresetn is synchronous, active low: control and configuration return to their reset
// values, matrix and rhs stores are not cleared and read as garbage until written
module jacobi_linear_solver_unit #(
    parameter int MAX_SIZE  = jls_pkg::MAX_SIZE_DEF,
    parameter int FRAC_BITS = jls_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [jls_pkg::S_TDATA_W-1:0]        s_tdata,   // row[3:0], col[7:4], value[39:8]
    input  logic [jls_pkg::OP_W-1:0]             s_tuser,   // opcode[1:0]
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [jls_pkg::M_TDATA_W-1:0]        m_tdata,   // index[3:0], solution[35:4],
                                                            // sweeps_done[51:36], zero[55:52]
    output logic [jls_pkg::STAT_W-1:0]           m_tuser,   // status[1:0]
    output logic                                 m_tlast,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [jls_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [jls_pkg::DATA_W-1:0]           cfg_data
);

    localparam int IW = $clog2(MAX_SIZE);
    localparam int DW = jls_pkg::DATA_W;
    localparam int RW = jls_pkg::ROW_W;
    localparam int SW = jls_pkg::SWEEP_W;

    // input field split
    logic [RW-1:0] in_row;
    logic [RW-1:0] in_col;
    logic [DW-1:0] in_value;
    logic          in_fire;
    logic          row_ok;
    logic          col_ok;
    logic          ld_a;
    logic          ld_b;
    logic          start;

    // configuration registers
    logic [jls_pkg::SIZE_W-1:0] size_reg;
    logic [SW-1:0]              limit_reg;
    logic [DW-1:0]              thresh_reg;
    logic                       cfg_fire;

    // output register
    logic                   m_tvalid_reg;
    logic [RW-1:0]          out_index_reg;
    logic [DW-1:0]          out_sol_reg;
    logic [SW-1:0]          out_sweeps_reg;
    jls_pkg::status_t       out_status_reg;
    logic                   out_last_reg;
    logic                   out_free;

    // controller to datapath
    jls_pkg::cmd_t          cmd;
    jls_pkg::dp_stat_t      dp_stat;
    logic [IW-1:0]          mat_row;
    logic [IW-1:0]          mat_col;
    logic [IW-1:0]          x_idx;
    logic                   idle;
    logic [SW-1:0]          sweeps;
    jls_pkg::status_t       status;
    logic                   last;
    logic [DW-1:0]          x_rd;

    assign in_row   = s_tdata[RW-1:0];
    assign in_col   = s_tdata[2*RW-1:RW];
    assign in_value = s_tdata[2*RW+DW-1:2*RW];

    // items are taken only between solves; a load completes in its transfer cycle
    assign s_tready = idle;
    assign in_fire  = s_tvalid & s_tready;
    assign row_ok   = int'(in_row) < MAX_SIZE;
    assign col_ok   = int'(in_col) < MAX_SIZE;
    assign ld_a     = in_fire && (s_tuser == jls_pkg::OP_LOAD_A) && row_ok && col_ok;
    assign ld_b     = in_fire && (s_tuser == jls_pkg::OP_LOAD_B) && row_ok;
    assign start    = in_fire && (s_tuser == jls_pkg::OP_START);

    // configuration is always accepted; unknown indexes are dropped
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg   <= jls_pkg::SIZE_RST;
            limit_reg  <= jls_pkg::LIMIT_RST;
            thresh_reg <= jls_pkg::THRESH_RST;
        end else if (cfg_fire) begin
            if (cfg_index == jls_pkg::CFG_SIZE) begin
                size_reg <= cfg_data[jls_pkg::SIZE_W-1:0];
            end else if (cfg_index == jls_pkg::CFG_LIMIT) begin
                limit_reg <= cfg_data[SW-1:0];
            end else if (cfg_index == jls_pkg::CFG_THRESH) begin
                thresh_reg <= cfg_data;
            end
        end
    end

    // result register: the slot frees when the consumer takes the transfer
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            out_index_reg  <= RW'(x_idx);
            out_sol_reg    <= x_rd;
            out_sweeps_reg <= sweeps;
            out_status_reg <= status;
            out_last_reg   <= last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(jls_pkg::M_TDATA_W-RW-DW-SW){1'b0}},
                       out_sweeps_reg, out_sol_reg, out_index_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    jls_ctrl #(
        .MAX_SIZE (MAX_SIZE)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (start),
        .size_i     (size_reg),
        .limit_i    (limit_reg),
        .out_free_i (out_free),
        .stat_i     (dp_stat),
        .cmd_o      (cmd),
        .mat_row_o  (mat_row),
        .mat_col_o  (mat_col),
        .x_idx_o    (x_idx),
        .idle_o     (idle),
        .sweeps_o   (sweeps),
        .status_o   (status),
        .last_o     (last)
    );

    jls_dp #(
        .MAX_SIZE  (MAX_SIZE),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ld_a_i     (ld_a),
        .ld_b_i     (ld_b),
        .ld_row_i   (IW'(in_row)),
        .ld_col_i   (IW'(in_col)),
        .ld_value_i (in_value),
        .cmd_i      (cmd),
        .mat_row_i  (mat_row),
        .mat_col_i  (mat_col),
        .x_idx_i    (x_idx),
        .thresh_i   (thresh_reg),
        .stat_o     (dp_stat),
        .x_rd_o     (x_rd)
    );

endmodule

FILE: tb/tb_top.sv
// self-checking testbench for jacobi_linear_solver_unit: stream driver, result monitor and
// an in-bench jacobi predictor checking every solution element; depends on jls_pkg and the rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import jls_pkg::*;

    // opcode 3 is not a member of opcode_t; the block must ignore it
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam longint SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam int RANDOM_ITEMS = 260;

    typedef struct {
        logic [OP_W-1:0] op;
        logic [3:0]      row;
        logic [3:0]      col;
        logic [31:0]     val;
    } load_item_t;

    typedef struct {
        logic [3:0]  index;
        logic [31:0] solution;
        logic [15:0] sweeps;
        status_t     status;
        logic        last;
    } solution_elem_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;   // row[3:0], col[7:4], value[39:8]
    logic [OP_W-1:0]      s_tuser = '0;   // opcode[1:0]
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;        // index[3:0], solution[35:4], sweeps_done[51:36]
    logic [STAT_W-1:0]    m_tuser;        // status[1:0]
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    cfg_reg_t             cfg_index = CFG_SIZE;
    logic [DATA_W-1:0]    cfg_data = '0;

    jacobi_linear_solver_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // items waiting for the driver, solution elements waiting for the block
    load_item_t     item_queue[$];
    solution_elem_t solution_queue[$];

    // predictor state: stores, solution vector and register copies
    logic [31:0] mat_store[256];
    logic [31:0] rhs_store[16];
    logic [31:0] x_vec[16];
    logic [4:0]  size_reg   = SIZE_RST;
    logic [15:0] limit_reg  = LIMIT_RST;
    logic [31:0] thresh_reg = THRESH_RST;

    // which entries the stimulus has written so far, so no unwritten entry is ever read
    bit a_set[256];
    bit b_set[16];

    int  errors = 0;
    int  random_items = 0;
    bit  counting = 0;
    bit  calm = 0;        // no idling on either side while set
    bit  s_took = 0;      // the item on the bus was transferred at the last rising edge
    int  s_gap = 0;
    int  m_stall = 0;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // safety net against a hung block
    initial begin
        #40_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic longint sx(logic [31:0] v);
        int t;
        t = v;
        return t;
    endfunction

    function automatic longint add_sat(longint a, longint b);
        if (b > 0 && a > SAT_MAX - b) return SAT_MAX;
        if (b < 0 && a < -SAT_MAX - b) return -SAT_MAX;
        return a + b;
    endfunction

    // full jacobi solve on the predictor state; queues one element per row in use
    task automatic solve_jacobi();
        int n, lim, sweeps, i, j;
        status_t st;
        logic [31:0] x_next[16];
        longint acc, num, q, d;
        longint unsigned ad, term, change;
        solution_elem_t e;
        n = size_reg;
        if (n < 1) n = 1;
        if (n > 16) n = 16;
        lim = (limit_reg == 0) ? 1 : limit_reg;
        for (i = 0; i < n; i++) x_vec[i] = rhs_store[i];
        sweeps = 0;
        st = RES_CONVERGED;
        for (i = 0; i < n; i++)
            if (mat_store[i*16 + i] == 0) st = RES_ZERO_DIAG;
        if (st != RES_ZERO_DIAG) begin
            forever begin
                change = 0;
                for (i = 0; i < n; i++) begin
                    acc = 0;
                    for (j = 0; j < n; j++)
                        if (i != j) acc = add_sat(acc, sx(mat_store[i*16 + j]) * sx(x_vec[j]));
                    num = add_sat(sx(rhs_store[i]) * 65536, -acc);
                    q = num / sx(mat_store[i*16 + i]);   // truncates toward zero
                    if (q > 64'sh7FFF_FFFF) q = 64'sh7FFF_FFFF;
                    if (q < -64'sh8000_0000) q = -64'sh8000_0000;
                    x_next[i] = q[31:0];
                    d = sx(x_next[i]) - sx(x_vec[i]);
                    ad = (d < 0) ? -d : d;
                    term = (ad * ad) >> 16;
                    change = (change > ~64'd0 - term) ? ~64'd0 : change + term;
                end
                for (i = 0; i < n; i++) x_vec[i] = x_next[i];
                sweeps++;
                if (change <= {32'd0, thresh_reg}) begin
                    st = RES_CONVERGED;
                    break;
                end
                if (sweeps >= lim) begin
                    st = RES_LIMIT;
                    break;
                end
            end
        end
        for (i = 0; i < n; i++) begin
            e.index = i;
            e.solution = x_vec[i];
            e.sweeps = sweeps;
            e.status = st;
            e.last = (i == n - 1);
            solution_queue.push_back(e);
        end
    endtask

    task automatic apply_item(load_item_t it);
        case (it.op)
            OP_LOAD_A: mat_store[{it.row, it.col}] = it.val;
            OP_LOAD_B: rhs_store[it.row] = it.val;
            OP_START:  solve_jacobi();
            default: ;  // unused opcode changes nothing
        endcase
    endtask

    // input driver: a new item goes out at the falling edge once the last one was transferred
    always @(negedge aclk) begin
        if (s_gap > 0) s_gap--;
        if (!s_tvalid || s_took) begin
            s_took = 0;
            if (aresetn && s_gap == 0 && item_queue.size() > 0) begin
                load_item_t it;
                it = item_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= it.op;
                s_tdata  <= {it.val, it.col, it.row};
                s_gap = pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side backpressure
    always @(negedge aclk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else if (m_stall > 0) begin
            m_stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            m_stall = pick_gap();
        end
    end

    // monitor: input transfers feed the predictor, result transfers are checked in order
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            load_item_t it;
            it.op  = s_tuser;
            it.row = s_tdata[3:0];
            it.col = s_tdata[7:4];
            it.val = s_tdata[39:8];
            apply_item(it);
            s_took = 1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (solution_queue.size() == 0) begin
                $display("%0t: result with nothing expected, got %h", $realtime, m_tdata);
                errors++;
            end else begin
                solution_elem_t e;
                e = solution_queue.pop_front();
                if (m_tdata[3:0] !== e.index) begin
                    $display("%0t: index expected %0d got %0d", $realtime, e.index, m_tdata[3:0]);
                    errors++;
                end
                if (m_tdata[35:4] !== e.solution) begin
                    $display("%0t: solution[%0d] expected %h got %h", $realtime, e.index,
                             e.solution, m_tdata[35:4]);
                    errors++;
                end
                if (m_tdata[51:36] !== e.sweeps) begin
                    $display("%0t: sweeps expected %0d got %0d", $realtime, e.sweeps,
                             m_tdata[51:36]);
                    errors++;
                end
                if (m_tuser !== e.status) begin
                    $display("%0t: status expected %0d got %0d", $realtime, e.status, m_tuser);
                    errors++;
                end
                if (m_tlast !== e.last) begin
                    $display("%0t: last expected %0b got %0b", $realtime, e.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    task automatic push_item(logic [OP_W-1:0] op, int row, int col, logic [31:0] val);
        load_item_t it;
        it.op = op;
        it.row = row;
        it.col = col;
        it.val = val;
        item_queue.push_back(it);
        if (op == OP_LOAD_A) a_set[row*16 + col] = 1;
        if (op == OP_LOAD_B) b_set[row] = 1;
        if (counting && op != OP_UNUSED) random_items++;
    endtask

    // diagonally dominant values keep most solves down to a handful of sweeps
    function automatic logic [31:0] diag_val(int n);
        int mag;
        mag = (2*n + 1 + $urandom_range(0, 2*n)) << 16;
        return $urandom_range(0, 1) ? mag : -mag;
    endfunction

    function automatic logic [31:0] off_val();
        return int'($urandom_range(0, 131072)) - 65536;
    endfunction

    function automatic logic [31:0] rhs_val();
        return int'($urandom_range(0, 2097152)) - 1048576;
    endfunction

    // fill every entry the solve will read that was never written, then start
    task automatic push_start(int n);
        int i, j;
        for (i = 0; i < n; i++) begin
            for (j = 0; j < n; j++)
                if (!a_set[i*16 + j]) push_item(OP_LOAD_A, i, j, (i == j) ? diag_val(n) : off_val());
            if (!b_set[i]) push_item(OP_LOAD_B, i, 0, rhs_val());
        end
        push_item(OP_START, $urandom_range(0, 15), $urandom_range(0, 15), $urandom());
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_SIZE:   size_reg = v[4:0];
            CFG_LIMIT:  limit_reg = v[15:0];
            CFG_THRESH: thresh_reg = v;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(int sz, int lim, logic [31:0] th);
        write_reg(CFG_SIZE, sz);
        write_reg(CFG_LIMIT, lim);
        write_reg(CFG_THRESH, th);
    endtask

    // wait until every item is transferred and every element has arrived, then let
    // trailing loads drain before the registers are touched again
    task automatic settle();
        while (item_queue.size() != 0 || s_tvalid || solution_queue.size() != 0)
            @(posedge aclk);
        repeat (16) @(posedge aclk);
    endtask

    initial begin
        int n, lim, starts, k, r, i;
        logic [31:0] th;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: extreme values, saturation, zero diagonal, unused opcode
        calm = 1;
        configure(2, 20, 66);
        push_item(OP_LOAD_A, 0, 0, 32'h0003_0000);
        push_item(OP_LOAD_A, 0, 1, 32'h0000_8000);
        push_item(OP_LOAD_A, 1, 0, 32'hFFFF_8000);
        push_item(OP_LOAD_A, 1, 1, 32'h0002_0000);
        push_item(OP_LOAD_B, 0, 0, 32'h7FFF_FFFF);
        push_item(OP_LOAD_B, 1, 15, 32'h8000_0000);
        push_start(2);
        push_item(OP_UNUSED, 15, 15, 32'hFFFF_FFFF);
        push_item(OP_LOAD_A, 15, 0, 32'h8000_0000);
        push_item(OP_LOAD_B, 15, 0, 32'h0000_0000);
        push_item(OP_LOAD_A, 1, 1, 32'h0000_0000);   // zero diagonal
        push_start(2);
        push_item(OP_LOAD_A, 1, 1, 32'h0000_0001);   // tiny diagonal, quotient saturates
        push_item(OP_LOAD_A, 0, 0, 32'hFFFF_FFFF);
        push_start(2);
        settle();

        // register extremes: size 1 and limit 0 read as 1, zero threshold
        calm = 0;
        configure(1, 0, 0);
        push_start(1);
        push_item(OP_LOAD_A, 0, 0, 32'h7FFF_FFFF);
        push_start(1);
        settle();
        configure(0, 1, 32'hFFFF_FFFF);
        push_start(1);
        settle();

        // oversized size register acts as the full 16 rows
        configure(31, 2, 0);
        push_start(16);
        for (k = 0; k < 4; k++) push_item(OP_LOAD_A, $urandom_range(0, 15),
                                          $urandom_range(0, 15), $urandom());
        push_start(16);
        settle();

        // largest limit with a system that settles on the first sweep
        configure(2, 65535, 32'hFFFF_FFFF);
        push_item(OP_LOAD_A, 0, 0, 32'h0001_0000);
        push_item(OP_LOAD_A, 0, 1, 32'h0000_0000);
        push_item(OP_LOAD_A, 1, 0, 32'h0000_0000);
        push_item(OP_LOAD_A, 1, 1, 32'h0001_0000);
        push_start(2);
        settle();

        // random phases: mostly well-formed reloads with random content, some noise
        counting = 1;
        while (random_items < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 5) == 0);
            n = ($urandom_range(0, 7) == 0) ? 8 : $urandom_range(1, 6);
            lim = (n > 6) ? $urandom_range(1, 8) : $urandom_range(1, 24);
            r = $urandom_range(0, 4);
            th = (r == 0) ? 32'd0 : (r == 1) ? 32'd66 : (r == 2) ? $urandom_range(0, 4096) :
                 (r == 3) ? $urandom_range(0, 1 << 20) : 32'hFFFF_FFFF;
            configure(n, lim, th);
            starts = $urandom_range(1, 3);
            for (i = 0; i < starts; i++) begin
                r = $urandom_range(0, 9);
                if (r < 7) begin
                    repeat ($urandom_range(0, 2*n)) begin
                        int row, col;
                        row = $urandom_range(0, n - 1);
                        col = $urandom_range(0, n - 1);
                        if ($urandom_range(0, 4) == 0)
                            push_item(OP_LOAD_A, row, col, $urandom());
                        else
                            push_item(OP_LOAD_A, row, col,
                                      (row == col) ? diag_val(n) : off_val());
                    end
                    repeat ($urandom_range(0, n))
                        push_item(OP_LOAD_B, $urandom_range(0, n - 1), $urandom_range(0, 15),
                                  ($urandom_range(0, 4) == 0) ? $urandom() : rhs_val());
                end else if (r < 9) begin
                    repeat ($urandom_range(1, 6)) begin
                        k = $urandom_range(0, 2);
                        if (k == 0) push_item(OP_UNUSED, $urandom_range(0, 15),
                                              $urandom_range(0, 15), $urandom());
                        else push_item(k == 1 ? OP_LOAD_A : OP_LOAD_B, $urandom_range(0, 15),
                                       $urandom_range(0, 15), $urandom());
                    end
                end else begin
                    k = $urandom_range(0, n - 1);
                    push_item(OP_LOAD_A, k, k, 32'h0000_0000);
                end
                push_start(n);
            end
            settle();
        end

        repeat (50) @(posedge aclk);
        if (errors == 0 && solution_queue.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hdl
hdl/jls_pkg.sv
hdl/jls_div.sv
hdl/jls_dp.sv
hdl/jls_ctrl.sv
hdl/jacobi_linear_solver_unit.sv
tb/tb_top.sv
